// ----- sv/qkv_pkg.sv -----
// Shared constants, payload types and sequencer states for the QKV projection block.
`default_nettype none

package qkv_pkg;

  // Sizes
  localparam int MAX_DIM   = 16;
  localparam int NPROJ     = 3;
  localparam int DATA_W    = 16;
  localparam int FRAC      = 12;
  localparam int ACC_W     = 40;
  localparam int CFG_W     = 5;
  localparam int CNT_W     = 5;
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int ACC_DEPTH = NPROJ * MAX_DIM;
  localparam int WT_DEPTH  = NPROJ * MAX_DIM * MAX_DIM;
  localparam int ACC_AW    = $clog2(ACC_DEPTH);
  localparam int WT_AW     = $clog2(WT_DEPTH);

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(MAX_DIM);
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic signed [DATA_W-1:0] RES_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] RES_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) <<< (FRAC - 1);

  // Input kinds
  localparam logic [1:0] KIND_WEIGHT = 2'd0;
  localparam logic [1:0] KIND_BIAS   = 2'd1;
  localparam logic [1:0] KIND_ELEM   = 2'd2;

  // Projections
  localparam logic [1:0] PROJ_QUERY = 2'd0;
  localparam logic [1:0] PROJ_VALUE = 2'd2;

  // Result status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SAT      = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;

  typedef struct packed {
    logic [1:0]               kind;
    logic [1:0]               projection;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         column;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               out_projection;
    logic [IDX_W-1:0]         out_index;
    logic signed [DATA_W-1:0] result;
    logic [1:0]               status;
    logic                     run_end;
  } out_item_t;

  // Control travelling with one operation through the shared unit
  typedef struct packed {
    logic              vld;
    logic              mac;
    logic [ACC_AW-1:0] tag;
  } alu_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_EMIT_ISSUE,
    S_EMIT_WAIT,
    S_ERR
  } state_t;

endpackage

`default_nettype wire

// ----- sv/qkv_linear_projection_core.sv -----
// Top level of the query/key/value projection: stores, sequencer and result register.
//
//  channel  direction  handshake                payload
//  in       input      in_valid / in_stall      in_item  (in_item_t)
//  out      output     out_valid / out_stall    out_item (out_item_t)
//  cfg      input      cfg_wr_en                cfg_wr_data (dim_in_use)
//
// A weight or bias load is written straight into its store. A token element in range issues
// 3*dim multiply-accumulates through the one shared unit and then drains; one out of range
// only drains. On the last element each of the 3*dim results is read, given its operand,
// added and rounded by the same unit; a length error gives one result.
// Reset is synchronous and needs no clearing pass: accumulator valid bits clear at once.
// in_stall is high whenever the sequencer is busy; a result held by out_stall stalls emission.
`default_nettype none

module qkv_linear_projection_core
  import qkv_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_item,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_item,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data
);

  state_t                    state, state_next;
  logic [1:0]                proj_ctr, proj_next;
  logic [IDX_W-1:0]          idx_ctr, idx_next;
  logic [CFG_W-1:0]          dim_reg;
  logic [CFG_W-1:0]          dim_eff;
  logic [CNT_W-1:0]          count;
  logic signed [DATA_W-1:0]  x_q;
  logic                      last_q;
  logic [IDX_W-1:0]          col_q;
  logic                      in_accept;
  logic                      out_free;
  logic                      idx_last, proj_last;
  logic                      elem_in_range;
  logic                      tok_end;
  logic                      out_load;
  out_item_t                 out_load_item;
  logic                      sum_held;

  // Stores
  logic signed [DATA_W-1:0]  wmem [WT_DEPTH];
  logic signed [DATA_W-1:0]  bmem [ACC_DEPTH];
  logic signed [ACC_W-1:0]   amem [ACC_DEPTH];
  logic [ACC_DEPTH-1:0]      acc_vld;

  logic                      wt_we, bs_we;
  logic [WT_AW-1:0]          wt_waddr, wt_raddr;
  logic [ACC_AW-1:0]         bs_waddr, acc_addr;

  // Read stage
  alu_ctl_t                  iss_ctl, rd_ctl;
  logic signed [DATA_W-1:0]  rd_w, rd_b;
  logic signed [ACC_W-1:0]   rd_acc;
  logic                      rd_acc_vld;

  // Shared unit
  alu_ctl_t                  sum_ctl;
  logic signed [ACC_W-1:0]   sum;
  logic                      alu_busy;

  // Rounding and saturation
  logic [ACC_W-FRAC-DATA_W:0] upper;
  logic                       sat;
  logic signed [DATA_W-1:0]   res_val;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Clamp the register into 1..MAX_DIM
  always_comb begin
    if (dim_reg == '0) begin
      dim_eff = CFG_W'(1);
    end else if (32'(dim_reg) > MAX_DIM) begin
      dim_eff = CFG_W'(MAX_DIM);
    end else begin
      dim_eff = dim_reg;
    end
  end

  assign idx_last      = ({1'b0, idx_ctr} == (dim_eff - CFG_W'(1)));
  assign proj_last     = (proj_ctr == PROJ_VALUE);
  assign elem_in_range = (count < CNT_W'(dim_eff));

  // Addresses
  assign wt_we    = in_accept && (in_item.kind == KIND_WEIGHT) &&
                    (32'(in_item.projection) < NPROJ) && (32'(in_item.row) < MAX_DIM) &&
                    (32'(in_item.column) < MAX_DIM);
  assign bs_we    = in_accept && (in_item.kind == KIND_BIAS) &&
                    (32'(in_item.projection) < NPROJ) && (32'(in_item.row) < MAX_DIM);
  assign wt_waddr = WT_AW'(in_item.projection) * WT_AW'(MAX_DIM * MAX_DIM) +
                    WT_AW'(in_item.row) * WT_AW'(MAX_DIM) + WT_AW'(in_item.column);
  assign bs_waddr = ACC_AW'(in_item.projection) * ACC_AW'(MAX_DIM) + ACC_AW'(in_item.row);
  assign wt_raddr = WT_AW'(proj_ctr) * WT_AW'(MAX_DIM * MAX_DIM) +
                    WT_AW'(idx_ctr) * WT_AW'(MAX_DIM) + WT_AW'(col_q);
  assign acc_addr = ACC_AW'(proj_ctr) * ACC_AW'(MAX_DIM) + ACC_AW'(idx_ctr);

  // Weight store
  always_ff @(posedge clk) begin
    if (wt_we) begin
      wmem[wt_waddr] <= in_item.value;
    end
    rd_w <= wmem[wt_raddr];
  end

  // Bias store
  always_ff @(posedge clk) begin
    if (bs_we) begin
      bmem[bs_waddr] <= in_item.value;
    end
    rd_b <= bmem[acc_addr];
  end

  // Accumulator store: write back from the shared unit, read at the issue address
  always_ff @(posedge clk) begin
    if (sum_ctl.vld && sum_ctl.mac) begin
      amem[sum_ctl.tag] <= sum;
    end
    rd_acc     <= amem[iss_ctl.tag];
    rd_acc_vld <= acc_vld[iss_ctl.tag];
  end

  // Accumulator valid bits: an entry not written this token reads as zero
  always_ff @(posedge clk) begin
    if (rst || tok_end) begin
      acc_vld <= '0;
    end else if (sum_ctl.vld && sum_ctl.mac) begin
      acc_vld[sum_ctl.tag] <= 1'b1;
    end
  end

  // Read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ctl <= '0;
    end else begin
      rd_ctl <= iss_ctl;
    end
  end

  qkv_alu u_alu (
    .clk     (clk),
    .rst     (rst),
    .op_ctl  (rd_ctl),
    .weight  (rd_w),
    .element (x_q),
    .bias    (rd_b),
    .acc     (rd_acc_vld ? rd_acc : '0),
    .sum_ctl (sum_ctl),
    .sum     (sum),
    .busy    (alu_busy)
  );

  // Round to Q4.12 (floor of the half-added sum) and clamp
  assign upper   = sum[ACC_W-1:FRAC+DATA_W-1];
  assign sat     = !((&upper) || !(|upper));
  assign res_val = sat ? (sum[ACC_W-1] ? RES_MIN : RES_MAX) : sum[FRAC+DATA_W-1:FRAC];

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_reg <= DIM_RESET;
    end else if (cfg_wr_en) begin
      dim_reg <= cfg_wr_data;
    end
  end

  // Element count and the captured element
  always_ff @(posedge clk) begin
    if (rst || tok_end) begin
      count <= '0;
    end else if (in_accept && (in_item.kind == KIND_ELEM) && (count != COUNT_MAX)) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && (in_item.kind == KIND_ELEM)) begin
      x_q    <= in_item.value;
      last_q <= in_item.last;
      col_q  <= count[IDX_W-1:0];
    end
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      proj_ctr <= '0;
      idx_ctr  <= '0;
    end else begin
      state    <= state_next;
      proj_ctr <= proj_next;
      idx_ctr  <= idx_next;
    end
  end

  // Hold a finished sum while the result register is full
  always_ff @(posedge clk) begin
    if (rst || out_load) begin
      sum_held <= 1'b0;
    end else if (state == S_EMIT_WAIT && sum_ctl.vld) begin
      sum_held <= 1'b1;
    end
  end

  // Next state, issue and result load
  always_comb begin
    state_next    = state;
    proj_next     = proj_ctr;
    idx_next      = idx_ctr;
    iss_ctl       = '0;
    iss_ctl.tag   = acc_addr;
    out_load      = 1'b0;
    out_load_item = '0;
    tok_end       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_accept && (in_item.kind == KIND_ELEM)) begin
          proj_next  = PROJ_QUERY;
          idx_next   = '0;
          state_next = elem_in_range ? S_MAC : S_DRAIN;
        end
      end
      S_MAC: begin
        iss_ctl.vld = 1'b1;
        iss_ctl.mac = 1'b1;
        if (idx_last) begin
          idx_next = '0;
          if (proj_last) begin
            proj_next  = PROJ_QUERY;
            state_next = S_DRAIN;
          end else begin
            proj_next = proj_ctr + 2'd1;
          end
        end else begin
          idx_next = idx_ctr + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (!rd_ctl.vld && !alu_busy) begin
          if (!last_q) begin
            state_next = S_IDLE;
          end else if (count != CNT_W'(dim_eff)) begin
            state_next = S_ERR;
          end else begin
            state_next = S_EMIT_ISSUE;
          end
        end
      end
      S_EMIT_ISSUE: begin
        iss_ctl.vld = 1'b1;
        state_next  = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if ((sum_ctl.vld || sum_held) && out_free) begin
          out_load                     = 1'b1;
          out_load_item.out_projection = proj_ctr;
          out_load_item.out_index      = idx_ctr;
          out_load_item.result         = res_val;
          out_load_item.status         = sat ? ST_SAT : ST_OK;
          out_load_item.run_end        = proj_last && idx_last;
          if (proj_last && idx_last) begin
            tok_end    = 1'b1;
            proj_next  = PROJ_QUERY;
            idx_next   = '0;
            state_next = S_IDLE;
          end else begin
            if (idx_last) begin
              idx_next  = '0;
              proj_next = proj_ctr + 2'd1;
            end else begin
              idx_next = idx_ctr + IDX_W'(1);
            end
            state_next = S_EMIT_ISSUE;
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_load                     = 1'b1;
          out_load_item.out_projection = PROJ_QUERY;
          out_load_item.out_index      = '0;
          out_load_item.result         = '0;
          out_load_item.status         = ST_MISMATCH;
          out_load_item.run_end        = 1'b1;
          tok_end                      = 1'b1;
          state_next                   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Result register: load a beat when free, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item <= out_load_item;
    end
  end

  // Checks
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> (!rd_ctl.vld && !alu_busy))
    else $error("input taken while the shared unit still holds work");

  a_mac_wb_phase: assert property (@(posedge clk) disable iff (rst)
    (sum_ctl.vld && sum_ctl.mac) |-> (state == S_MAC || state == S_DRAIN))
    else $error("accumulator write back outside the accumulate phase");

  a_tok_clear: assert property (@(posedge clk) disable iff (rst)
    tok_end |=> (count == '0 && acc_vld == '0))
    else $error("token end left count or accumulators set");

  a_err_ends: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_load_item.status == ST_MISMATCH) |-> out_load_item.run_end)
    else $error("length error result not marked as run end");

  a_emit_wait_only: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_load_item.status != ST_MISMATCH) |-> (state == S_EMIT_WAIT))
    else $error("projection result loaded outside emission");

endmodule

`default_nettype wire

// ----- sv/qkv_alu.sv -----
// Shared two-stage multiply-accumulate and bias-round adder.
`default_nettype none

module qkv_alu
  import qkv_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire alu_ctl_t                 op_ctl,
  input  wire logic signed [DATA_W-1:0] weight,
  input  wire logic signed [DATA_W-1:0] element,
  input  wire logic signed [DATA_W-1:0] bias,
  input  wire logic signed [ACC_W-1:0]  acc,
  output alu_ctl_t                      sum_ctl,
  output logic signed [ACC_W-1:0]       sum,
  output logic                          busy
);

  alu_ctl_t                  s1_ctl;
  logic signed [ACC_W-1:0]   s1_acc;
  logic signed [ACC_W-1:0]   s1_opd;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [ACC_W-1:0]   bias_opd;

  // Form the operand: exact product, or bias moved to Q16.24 plus half an LSB
  assign prod     = weight * element;
  assign bias_opd = {{(ACC_W-DATA_W-FRAC){bias[DATA_W-1]}}, bias, {FRAC{1'b0}}} + ROUND_HALF;

  // Stage one: register operand and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else begin
      s1_ctl <= op_ctl;
    end
    if (op_ctl.vld) begin
      s1_acc <= acc;
      s1_opd <= op_ctl.mac ? ACC_W'(prod) : bias_opd;
    end
  end

  // Stage two: add; hold the sum until the next operation arrives
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_ctl <= '0;
    end else begin
      sum_ctl <= s1_ctl;
    end
    if (s1_ctl.vld) begin
      sum <= s1_acc + s1_opd;
    end
  end

  assign busy = s1_ctl.vld | sum_ctl.vld;

endmodule

`default_nettype wire
